// ===== design/generational_handle_table_top_assert.svh =====
// Assertion helpers shared by the handle table modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define GHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ght_pkg.sv =====
package ght_pkg;

    // Request type codes.
    localparam logic [2:0] OP_OPEN   = 3'd0;
    localparam logic [2:0] OP_CLOSE  = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam int MOUNT_W = 32;
    localparam int INDEX_W = 16;

    // One incoming request.
    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [INDEX_W-1:0] parent_index;
        logic signed [INDEX_W-1:0] child_index;
    } ght_req_t;

    // One result.
    typedef struct packed {
        logic                      accepted;
        logic                      child_valid;
        logic signed [INDEX_W-1:0] child_parent;
    } ght_rsp_t;

    // Child slot word as kept in the child memory.
    typedef struct packed {
        logic               live;
        logic [INDEX_W-1:0] parent;
        logic [MOUNT_W-1:0] mount;
    } ght_child_t;

    localparam int CHILD_W = $bits(ght_child_t);

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_CHECK
    } ght_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
        logic check;
    } ght_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic need_check;
    } ght_sts_t;

endpackage

// ===== design/generational_handle_table_top.sv =====
// Generational handle table: one request at a time, taken when start is high and busy low.
// Open, close, add, remove, other requests and a query of an out-of-range child end after the
// execute step; a query of an in-range child adds a check step, since the stored parent index
// read from the child memory addresses the parent memory next. The result strobe (done) rises
// the cycle after the last step, for exactly one cycle; the receiver cannot stall it. A new
// request may be taken in that same cycle. After reset busy stays high while the block clears
// both slot memories, as many entries as the larger of PARENT_SLOTS and CHILD_SLOTS.
module generational_handle_table_top #(
    parameter int PARENT_SLOTS = 64,
    parameter int CHILD_SLOTS  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ght_pkg::ght_req_t req,
    output logic              done,
    output ght_pkg::ght_rsp_t rsp
);
    import ght_pkg::*;

    ght_ctl_t ctl;
    ght_sts_t sts;

    // Sequencer.
    ght_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Slot memories, mount counter and result register.
    ght_dp #(
        .PARENT_SLOTS (PARENT_SLOTS),
        .CHILD_SLOTS  (CHILD_SLOTS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp),
        .done  (done)
    );

endmodule

// ===== design/ght_ram.sv =====
module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ght_ctrl.sv =====
module ght_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ght_pkg::ght_sts_t sts,
    output ght_pkg::ght_ctl_t ctl,
    output logic              busy
);
    import ght_pkg::*;
    `include "generational_handle_table_top_assert.svh"

    ght_state_t state_reg;
    ght_state_t state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.need_check ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                ctl.accept = start;
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            ST_CHECK:
            begin
                ctl.check = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // The parent compare always follows the child lookup, and the clearing
    // pass runs only once after reset.
    `GHT_ASSERT_IMPL(a_check_after_exec, state_reg == ST_CHECK, $past(state_reg) == ST_EXEC, "check without lookup")
    `GHT_ASSERT_NEXT(a_clear_once, state_reg != ST_CLEAR, state_reg != ST_CLEAR, "clearing pass restarted")

endmodule

// ===== design/ght_dp.sv =====
module ght_dp #(
    parameter int PARENT_SLOTS = 64,
    parameter int CHILD_SLOTS  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ght_pkg::ght_ctl_t ctl,
    output ght_pkg::ght_sts_t sts,
    input  ght_pkg::ght_req_t req,
    output ght_pkg::ght_rsp_t rsp,
    output logic              done
);
    import ght_pkg::*;
    `include "generational_handle_table_top_assert.svh"

    localparam int PAW     = (PARENT_SLOTS > 1) ? $clog2(PARENT_SLOTS) : 1;
    localparam int CAW     = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
    localparam int CLR_LEN = (PARENT_SLOTS > CHILD_SLOTS) ? PARENT_SLOTS : CHILD_SLOTS;
    localparam int CW      = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

    ght_req_t           req_reg;
    ght_rsp_t           rsp_reg;
    ght_rsp_t           rsp_next;
    logic               done_reg;
    logic               done_next;
    logic [MOUNT_W-1:0] mount_reg;
    logic [MOUNT_W-1:0] mount_next;
    logic [MOUNT_W-1:0] mount_inc;
    logic [CW-1:0]      clr_cnt_reg;
    logic [CW-1:0]      clr_cnt_next;

    logic               p_ok;
    logic               c_ok;
    logic               sp_ok;

    logic               p_we;
    logic [PAW-1:0]     p_waddr;
    logic [MOUNT_W-1:0] p_wdata;
    logic               p_re;
    logic [PAW-1:0]     p_raddr;
    logic [MOUNT_W-1:0] p_rdata;

    logic               c_we;
    logic [CAW-1:0]     c_waddr;
    ght_child_t         c_wdata;
    logic               c_re;
    logic [CAW-1:0]     c_raddr;
    logic [CHILD_W-1:0] c_rdata;
    ght_child_t         c_rd;

    // Parent mounts; a zero mount marks a dead parent.
    ght_ram #(
        .WIDTH (MOUNT_W),
        .DEPTH (PARENT_SLOTS)
    ) u_parent_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Child slots: live flag, stored parent index and saved mount.
    ght_ram #(
        .WIDTH (CHILD_W),
        .DEPTH (CHILD_SLOTS)
    ) u_child_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Range checks on the latched request and on the stored parent index.
    always_comb
    begin
        c_rd  = ght_child_t'(c_rdata);
        p_ok  = !req_reg.parent_index[INDEX_W-1]
                && ($unsigned(req_reg.parent_index) < INDEX_W'(PARENT_SLOTS));
        c_ok  = !req_reg.child_index[INDEX_W-1]
                && ($unsigned(req_reg.child_index) < INDEX_W'(CHILD_SLOTS));
        sp_ok = !c_rd.parent[INDEX_W-1] && (c_rd.parent < INDEX_W'(PARENT_SLOTS));
        sts.need_check = (req_reg.req_type == OP_QUERY) && c_ok;
        sts.clear_last = (clr_cnt_reg == CW'(CLR_LEN - 1));
    end

    // Next mount number wraps and skips zero.
    assign mount_inc = (mount_reg == '1) ? MOUNT_W'(1) : mount_reg + MOUNT_W'(1);

    // Memory reads: both slots on acceptance, then the stored parent for a query.
    always_comb
    begin
        c_re    = ctl.accept;
        c_raddr = req.child_index[CAW-1:0];
        p_re    = ctl.accept || (ctl.exec && (req_reg.req_type == OP_QUERY));
        p_raddr = ctl.accept ? req.parent_index[PAW-1:0] : c_rd.parent[PAW-1:0];
    end

    // Memory writes, mount counter and result.
    always_comb
    begin
        p_we         = 1'b0;
        p_waddr      = req_reg.parent_index[PAW-1:0];
        p_wdata      = '0;
        c_we         = 1'b0;
        c_waddr      = req_reg.child_index[CAW-1:0];
        c_wdata      = '0;
        mount_next   = mount_reg;
        clr_cnt_next = clr_cnt_reg;
        rsp_next     = rsp_reg;
        done_next    = 1'b0;

        if (ctl.clear)
        begin
            p_we         = (32'(clr_cnt_reg) < 32'(PARENT_SLOTS));
            p_waddr      = clr_cnt_reg[PAW-1:0];
            c_we         = (32'(clr_cnt_reg) < 32'(CHILD_SLOTS));
            c_waddr      = clr_cnt_reg[CAW-1:0];
            clr_cnt_next = clr_cnt_reg + CW'(1);
        end

        if (ctl.exec)
        begin
            rsp_next  = '0;
            done_next = !sts.need_check;
            case (req_reg.req_type)
                OP_OPEN:
                begin
                    if (p_ok)
                    begin
                        p_we              = 1'b1;
                        p_wdata           = mount_inc;
                        mount_next        = mount_inc;
                        rsp_next.accepted = 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    if (p_ok)
                    begin
                        p_we              = 1'b1;
                        rsp_next.accepted = 1'b1;
                    end
                end
                OP_ADD:
                begin
                    if (c_ok)
                    begin
                        c_we              = 1'b1;
                        c_wdata.live      = 1'b1;
                        c_wdata.parent    = req_reg.parent_index;
                        c_wdata.mount     = p_ok ? p_rdata : '0;
                        rsp_next.accepted = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (c_ok)
                    begin
                        c_we              = 1'b1;
                        rsp_next.accepted = 1'b1;
                    end
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end

        // Query compare: live child, live parent in range, matching mount.
        if (ctl.check)
        begin
            rsp_next = '0;
            done_next = 1'b1;
            if (c_rd.live && sp_ok && (p_rdata != '0) && (c_rd.mount == p_rdata))
            begin
                rsp_next.child_valid  = 1'b1;
                rsp_next.child_parent = c_rd.parent;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_reg   <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mount_reg   <= mount_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

    // A result is either a lifecycle acknowledge or a query answer, only the
    // sequencer's last step raises the strobe, and both tables are written
    // together only while clearing.
    `GHT_ASSERT_IMPL(a_rsp_kind, done_reg, !(rsp_reg.accepted && rsp_reg.child_valid), "mixed result")
    `GHT_ASSERT_IMPL(a_done_src, done_reg, $past(ctl.exec || ctl.check), "stray result strobe")
    `GHT_ASSERT_IMPL(a_dual_write, p_we && c_we, ctl.clear, "both tables written outside clear")

endmodule

// ===== sim/tb_generational_handle_table_top.sv =====
module tb_generational_handle_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam int PARENT_SLOTS = 64;
    localparam int CHILD_SLOTS  = 256;

    // Request types beyond query are ignored by the block.
    localparam logic [2:0] OP_OTHER_LO = 3'd5;
    localparam logic [2:0] OP_OTHER_HI = 3'd7;

    localparam int PHASE_ITEMS = 400;

    // Tracks the slot tables and the mount counter, and holds the results
    // that accepted requests still owe.
    class handle_table_sb #(int PSLOTS = 64, int CSLOTS = 256);
        bit                 p_live[PSLOTS];
        logic [MOUNT_W-1:0] p_mount[PSLOTS];
        bit                 c_live[CSLOTS];
        logic [INDEX_W-1:0] c_parent[CSLOTS];
        logic [MOUNT_W-1:0] c_mount[CSLOTS];
        logic [MOUNT_W-1:0] mount_ctr;
        ght_rsp_t           due_results[$];
        int                 mismatches;

        function new();
            foreach (p_live[i])
            begin
                p_live[i]  = 1'b0;
                p_mount[i] = '0;
            end
            foreach (c_live[i])
            begin
                c_live[i]   = 1'b0;
                c_parent[i] = '0;
                c_mount[i]  = '0;
            end
            mount_ctr  = '0;
            mismatches = 0;
        endfunction

        function bit fits(int idx, int slots);
            return idx >= 0 && idx < slots;
        endfunction

        // Applies one request to the slot tables and returns what the block
        // should answer.
        function ght_rsp_t apply_request(ght_req_t r);
            int       p;
            int       c;
            int       sp;
            ght_rsp_t o;
            p = $signed(r.parent_index);
            c = $signed(r.child_index);
            o = '0;
            case (r.req_type)
                OP_OPEN:
                begin
                    if (fits(p, PSLOTS))
                    begin
                        // The mount counter wraps but never hands out zero.
                        mount_ctr = mount_ctr + 1'b1;
                        if (mount_ctr == '0)
                            mount_ctr = mount_ctr + 1'b1;
                        p_live[p]  = 1'b1;
                        p_mount[p] = mount_ctr;
                        o.accepted = 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    if (fits(p, PSLOTS))
                    begin
                        p_live[p]  = 1'b0;
                        p_mount[p] = '0;
                        o.accepted = 1'b1;
                    end
                end
                OP_ADD:
                begin
                    if (fits(c, CSLOTS))
                    begin
                        // A dead or out-of-range parent still yields a live child,
                        // with mount zero so it can never be valid.
                        c_live[c]   = 1'b1;
                        c_parent[c] = r.parent_index;
                        c_mount[c]  = (fits(p, PSLOTS) && p_live[p]) ? p_mount[p] : '0;
                        o.accepted  = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (fits(c, CSLOTS))
                    begin
                        c_live[c]   = 1'b0;
                        c_parent[c] = '0;
                        c_mount[c]  = '0;
                        o.accepted  = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    if (fits(c, CSLOTS) && c_live[c])
                    begin
                        sp = $signed(c_parent[c]);
                        if (fits(sp, PSLOTS) && p_live[sp] && c_mount[c] == p_mount[sp])
                        begin
                            o.child_valid  = 1'b1;
                            o.child_parent = c_parent[c];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            return o;
        endfunction

        function void note_request(ght_req_t r);
            due_results.push_back(apply_request(r));
        endfunction

        function void check_result(ght_rsp_t got);
            ght_rsp_t want;
            if (due_results.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.accepted !== want.accepted)
            begin
                $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
                mismatches++;
            end
            if (got.child_valid !== want.child_valid)
            begin
                $error("child_valid: expected %0d actual %0d",
                       want.child_valid, got.child_valid);
                mismatches++;
            end
            if (got.child_parent !== want.child_parent)
            begin
                $error("child_parent: expected %0d actual %0d",
                       want.child_parent, got.child_parent);
                mismatches++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ght_req_t req;
    logic     done;
    ght_rsp_t rsp;

    handle_table_sb #(PARENT_SLOTS, CHILD_SLOTS) sb;

    generational_handle_table_top #(
        .PARENT_SLOTS (PARENT_SLOTS),
        .CHILD_SLOTS  (CHILD_SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Watch both handshakes at each edge; results are checked before the
    // request taken at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_request(req);
        end
    end

    function automatic ght_req_t make_request(logic [2:0] op, int p, int c);
        ght_req_t r;
        r = '0;
        r.req_type     = op;
        r.parent_index = 16'(p);
        r.child_index  = 16'(c);
        return r;
    endfunction

    // Mostly a small hot set of slots so that lifecycles interact, with the
    // full range, the edges and raw 16-bit values mixed in.
    function automatic logic [INDEX_W-1:0] pick_index(int slots, int hot);
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return 16'($urandom_range(0, hot - 1));
        else if (k < 85)
            return 16'($urandom_range(0, slots - 1));
        else if (k < 93)
        begin
            case ($urandom_range(0, 3))
                0: return 16'(-1);
                1: return 16'(slots);
                2: return 16'h8000;
                default: return 16'h7fff;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic ght_req_t random_request();
        ght_req_t r;
        int       k;
        r.parent_index = pick_index(PARENT_SLOTS, 8);
        r.child_index  = pick_index(CHILD_SLOTS, 16);
        k = $urandom_range(0, 99);
        if (k < 20)
            r.req_type = OP_OPEN;
        else if (k < 30)
            r.req_type = OP_CLOSE;
        else if (k < 52)
            r.req_type = OP_ADD;
        else if (k < 60)
            r.req_type = OP_REMOVE;
        else if (k < 93)
            r.req_type = OP_QUERY;
        else
            r.req_type = 3'($urandom_range(OP_OTHER_LO, OP_OTHER_HI));
        return r;
    endfunction

    // Present one request, idling first at the given rate, and return at the
    // edge where it is taken.
    task automatic send_request(ght_req_t r, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold off new requests until every owed result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct);
        ght_req_t r;
        int       count;
        count = 0;
        while (count < PHASE_ITEMS)
        begin
            r = random_request();
            send_request(r, idle_pct);
            if (r.req_type <= OP_QUERY)
                count++;
        end
        drain();
    endtask

    initial
    begin
        sb    = new();
        clk   = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: edges of the index ranges, every request type,
        // stale children after close and reopen, dead and bogus parents.
        send_request(make_request(OP_QUERY, 0, 0), 0);
        send_request(make_request(OP_OPEN, 0, 0), 0);
        send_request(make_request(OP_OPEN, PARENT_SLOTS - 1, 0), 0);
        send_request(make_request(OP_OPEN, PARENT_SLOTS, 0), 0);
        send_request(make_request(OP_OPEN, -1, 0), 0);
        send_request(make_request(OP_ADD, 0, 0), 0);
        send_request(make_request(OP_ADD, PARENT_SLOTS - 1, CHILD_SLOTS - 1), 0);
        send_request(make_request(OP_ADD, 0, CHILD_SLOTS), 0);
        send_request(make_request(OP_ADD, 0, -32768), 0);
        send_request(make_request(OP_QUERY, 0, 0), 0);
        send_request(make_request(OP_QUERY, 0, CHILD_SLOTS - 1), 0);
        send_request(make_request(OP_ADD, 5, 1), 0);
        send_request(make_request(OP_ADD, -32768, 2), 0);
        send_request(make_request(OP_QUERY, 0, 1), 0);
        send_request(make_request(OP_QUERY, 0, 2), 0);
        send_request(make_request(OP_CLOSE, 0, 0), 0);
        send_request(make_request(OP_QUERY, 0, 0), 0);
        send_request(make_request(OP_OPEN, 0, 0), 0);
        send_request(make_request(OP_QUERY, 0, 0), 0);
        send_request(make_request(OP_REMOVE, 0, CHILD_SLOTS - 1), 0);
        send_request(make_request(OP_QUERY, 0, CHILD_SLOTS - 1), 0);
        send_request(make_request(OP_REMOVE, 0, 32767), 0);
        send_request(make_request(OP_CLOSE, 32767, 0), 0);
        send_request(make_request(OP_OTHER_LO, 32767, -1), 0);
        send_request(make_request(3'(OP_OTHER_LO + 1), -1, 32767), 0);
        send_request(make_request(OP_OTHER_HI, 0, 0), 0);
        send_request(make_request(OP_QUERY, 32767, -1), 0);
        drain();

        // Random traffic at several sender idle rates.
        run_phase(0);
        run_phase(58);
        run_phase(0);
        run_phase(37);

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ght_pkg.sv
design/ght_ram.sv
design/ght_ctrl.sv
design/ght_dp.sv
design/generational_handle_table_top.sv
sim/tb_generational_handle_table_top.sv
